// ----- rtl/ljap_pkg.sv -----
// package for the lennard-jones attractive pair potential block
// holds fixed-point widths, region codes and the pipeline side-band struct
// no dependencies
package ljap_pkg;

  localparam int NumSpecies = 4;
  localparam int SpecW      = 2;
  localparam int IdxW       = 4;
  localparam int DepthT     = NumSpecies * NumSpecies;
  localparam int ValW       = 24;
  localparam int QW         = 31;   // Q0.30 ratio, up to 2^30
  localparam int QuoW       = 55;   // sigma << 30 fits 54 bits plus headroom

  localparam logic [1:0] RegionCore   = 2'd0;
  localparam logic [1:0] RegionWell   = 2'd1;
  localparam logic [1:0] RegionTail   = 2'd2;
  localparam logic [1:0] RegionBeyond = 2'd3;

  localparam logic CmdEval = 1'b0;
  localparam logic CmdLoad = 1'b1;

  localparam logic [QW-1:0] Q30One     = QW'(64'h4000_0000);
  localparam logic [QW-1:0] Q30Half    = QW'(64'h2000_0000);
  localparam logic [QW-1:0] Q30Quarter = QW'(64'h1000_0000);

  // side-band carried down the pipeline with each evaluate
  typedef struct packed {
    logic [1:0]      region;
    logic            compute;   // tail or well: energy is computed
    logic            shift;     // subtract value at cutoff
    logic [ValW-1:0] eps;
  } side_t;

  function automatic logic [QW-1:0] mulq(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [2*QW-1:0] p;
    p = {{QW{1'b0}}, a} * {{QW{1'b0}}, b};
    return p[30 +: QW];
  endfunction

endpackage

// ----- rtl/ljap_stream_if.sv -----
// valid/ready channel interface with source and sink modports
// depends on nothing; payload type is a parameter-free logic vector width
interface ljap_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [1:0]  species_i;
  logic [1:0]  species_j;
  logic [23:0] distance;
  logic [23:0] sigma_value;
  logic [23:0] epsilon_value;
  logic [23:0] cutoff_value;
  modport source (output valid, cmd, species_i, species_j, distance, sigma_value,
                  epsilon_value, cutoff_value, input ready);
  modport sink (input valid, cmd, species_i, species_j, distance, sigma_value,
                epsilon_value, cutoff_value, output ready);
endinterface

interface ljap_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] energy;
  logic [1:0]         region;
  logic               saturated;
  modport source (output valid, energy, region, saturated, input ready);
  modport sink (input valid, energy, region, saturated, output ready);
endinterface

// ----- rtl/lj_attractive_pair_potential.sv -----
// top level of the lennard-jones attractive pair potential pipeline
// depends on ljap_pkg, ljap_stream_if, ljap_div and ljap_pow
//
// One item enters per cycle while the pipeline advances, and the result is
// formed through 39 register stages after its transfer: a register for
// table lookup, 31 quotient stages of the two ratio dividers (sigma/r and
// sigma/cutoff run in parallel), 4 multiply stages for the powers, then
// difference, scale, and round-and-saturate stages. A load item writes the
// three per-pair tables at its transfer and yields no result. The whole
// pipeline advances only when the output register is free or being taken,
// so a stall on the result side holds every stage. Distances and sigma
// share one fixed-point format.
module lj_attractive_pair_potential (
  input  logic              clk,
  input  logic              rst_n,
  ljap_in_if.sink           in_ch,
  ljap_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [1:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  localparam int VW = ljap_pkg::ValW;
  localparam int QW = ljap_pkg::QW;
  localparam int DivLat = QW;   // divider stages
  localparam int PowLat = 4;    // power stages
  localparam int MidLat = DivLat + PowLat;

  // configuration register
  logic cut_shift_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {31'd0, cut_shift_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_shift_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      cut_shift_r <= cfg_pwdata[0];
    end
  end

  // pipeline advance
  logic out_valid_r;
  logic adv;
  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  logic in_xfer;
  assign in_xfer = in_ch.valid && in_ch.ready;

  // per-pair tables, flop arrays read at one address
  logic [VW-1:0] sig_tab [ljap_pkg::DepthT];
  logic [VW-1:0] eps_tab [ljap_pkg::DepthT];
  logic [VW-1:0] cut_tab [ljap_pkg::DepthT];
  logic [ljap_pkg::IdxW-1:0] in_idx;
  assign in_idx = {in_ch.species_i, in_ch.species_j};

  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.cmd == ljap_pkg::CmdLoad) begin
      sig_tab[in_idx] <= in_ch.sigma_value;
      eps_tab[in_idx] <= in_ch.epsilon_value;
      cut_tab[in_idx] <= in_ch.cutoff_value;
    end
  end

  // stage 0: lookup and region classification
  logic           s0_v_r;
  logic [VW-1:0]  s0_sig_r, s0_cut_r, s0_r_r;
  ljap_pkg::side_t s0_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_xfer && in_ch.cmd == ljap_pkg::CmdEval;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sig_r <= sig_tab[in_idx];
      s0_cut_r <= cut_tab[in_idx];
      s0_r_r   <= in_ch.distance;
      s0_side_r.eps   <= eps_tab[in_idx];
      s0_side_r.shift <= cut_shift_r;
      if (in_ch.distance < sig_tab[in_idx]) begin
        s0_side_r.region  <= ljap_pkg::RegionCore;
        s0_side_r.compute <= 1'b0;
      end else if (cut_shift_r && in_ch.distance > cut_tab[in_idx]) begin
        s0_side_r.region  <= ljap_pkg::RegionBeyond;
        s0_side_r.compute <= 1'b0;
      end else begin
        s0_side_r.region  <= ljap_pkg::RegionTail;
        s0_side_r.compute <= 1'b1;
      end
    end
  end

  // ratio dividers and power units
  logic [QW-1:0] xr, xc, r6, r12, c6, c12;
  ljap_div u_div_r (.clk(clk), .en(adv), .num(s0_sig_r), .den(s0_r_r),   .quo(xr));
  ljap_div u_div_c (.clk(clk), .en(adv), .num(s0_sig_r), .den(s0_cut_r), .quo(xc));
  ljap_pow u_pow_r (.clk(clk), .en(adv), .x(xr), .p6(r6), .p12(r12));
  ljap_pow u_pow_c (.clk(clk), .en(adv), .x(xc), .p6(c6), .p12(c12));

  // side-band delay line matching divider plus power latency
  logic            dl_v_r    [MidLat];
  ljap_pkg::side_t dl_side_r [MidLat];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MidLat; i++) dl_v_r[i] <= 1'b0;
    end else if (adv) begin
      dl_v_r[0] <= s0_v_r;
      for (int i = 1; i < MidLat; i++) dl_v_r[i] <= dl_v_r[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dl_side_r[0] <= s0_side_r;
      for (int i = 1; i < MidLat; i++) dl_side_r[i] <= dl_side_r[i-1];
    end
  end

  // stage a: clamp and difference
  logic              sa_v_r;
  ljap_pkg::side_t   sa_side_r;
  ljap_pkg::side_t   sa_side_nxt;
  logic              sa_neg_r;
  logic [QW:0]       sa_mag_r;
  logic signed [QW+2:0] d_nxt;
  logic [QW-1:0]     x6c, x12c;
  logic              clamp;
  always_comb begin
    clamp = r6 > ljap_pkg::Q30Half;
    x6c   = clamp ? ljap_pkg::Q30Half : r6;
    x12c  = clamp ? ljap_pkg::Q30Quarter : r12;
    d_nxt = $signed({3'b0, x12c}) - $signed({3'b0, x6c});
    if (dl_side_r[MidLat-1].shift)
      d_nxt = d_nxt - ($signed({3'b0, c12}) - $signed({3'b0, c6}));
    sa_side_nxt = dl_side_r[MidLat-1];
    if (sa_side_nxt.compute && clamp)
      sa_side_nxt.region = ljap_pkg::RegionWell;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
    end else if (adv) begin
      sa_v_r <= dl_v_r[MidLat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sa_side_r <= sa_side_nxt;
      sa_neg_r <= d_nxt[QW+2];
      sa_mag_r <= d_nxt[QW+2] ? (QW+1)'(-d_nxt) : (QW+1)'(d_nxt);
    end
  end

  // stage b: scale by epsilon (24 x 32 multiply)
  logic            sb_v_r;
  ljap_pkg::side_t sb_side_r;
  logic            sb_neg_r;
  logic [VW+QW:0]  sb_prod_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_v_r <= 1'b0;
    end else if (adv) begin
      sb_v_r <= sa_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_side_r <= sa_side_r;
      sb_neg_r  <= sa_neg_r;
      sb_prod_r <= (VW+QW+1)'({{(QW+1){1'b0}}, sa_side_r.eps} * {{VW{1'b0}}, sa_mag_r});
    end
  end

  // stage c: times four, round half up, saturate into output register
  logic [VW+QW+3:0] rnd;
  logic [VW+QW-27:0] rq;
  logic signed [31:0] e_nxt;
  logic sat_nxt;
  always_comb begin
    rnd = {sb_prod_r, 2'b00} + (VW+QW+4)'(64'h2000_0000);
    rq  = rnd[VW+QW+3:30];
    sat_nxt = 1'b0;
    if (!sb_side_r.compute) begin
      e_nxt = '0;
    end else if (!sb_neg_r) begin
      if (32'(rq) > 32'h7FFF_FFFF) begin
        e_nxt = 32'sh7FFF_FFFF;
        sat_nxt = 1'b1;
      end else begin
        e_nxt = $signed(32'(rq));
      end
    end else begin
      if (32'(rq) > 32'h8000_0000) begin
        e_nxt = 32'sh8000_0000;
        sat_nxt = 1'b1;
      end else begin
        e_nxt = -$signed(32'(rq));
      end
    end
  end

  logic signed [31:0] energy_r;
  logic [1:0]         region_r;
  logic               sat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sb_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      energy_r <= e_nxt;
      region_r <= sb_side_r.region;
      sat_r    <= sat_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.energy    = energy_r;
  assign out_ch.region    = region_r;
  assign out_ch.saturated = sat_r;

  // checks
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(energy_r))
    else $error("result lost under stall");
  a_core_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (region_r == ljap_pkg::RegionCore || region_r == ljap_pkg::RegionBeyond)
    |-> energy_r == 32'sd0 && !sat_r)
    else $error("nonzero energy outside computed regions");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled while output free");
endmodule

// ----- rtl/ljap_div.sv -----
// pipelined restoring divider giving floor(num*2^30/den) clamped to 2^30
// one quotient bit per stage, 31 stages; uses ljap_pkg
module ljap_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ljap_pkg::ValW-1:0]    num,
  input  logic [ljap_pkg::ValW-1:0]    den,
  output logic [ljap_pkg::QW-1:0]      quo
);
  localparam int N = ljap_pkg::QW;
  localparam int RW = ljap_pkg::ValW + 1;

  // stage k holds partial remainder, divisor and quotient bits so far
  logic [RW-1:0]              rem_r [N+1];
  logic [ljap_pkg::ValW-1:0]  den_r [N+1];
  logic [N-1:0]               q_r   [N+1];
  logic                       hi_r  [N+1];  // quotient already above 2^30

  always_comb begin
    rem_r[0] = '0;
    den_r[0] = den;
    q_r[0]   = '0;
    hi_r[0]  = 1'b0;
  end

  // first step compares num with den directly (weight 2^30)
  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_st
      logic [RW:0] trial;
      logic [RW-1:0] start;
      always_comb begin
        start = (k == 0) ? RW'(num) : rem_r[k];
        trial = {1'b0, start} - {2'b0, den_r[k]};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[k+1] <= den_r[k];
          if (!trial[RW] && den_r[k] != '0) begin
            rem_r[k+1] <= RW'(trial[RW-1:0]) << 1;
            q_r[k+1]   <= q_r[k] | (N'(1) << (N-1-k));
          end else begin
            rem_r[k+1] <= start << 1;
            q_r[k+1]   <= q_r[k];
          end
          hi_r[k+1] <= (k == 0) ? (!trial[RW] && den_r[k] != '0 &&
                                   RW'(trial[RW-1:0]) != '0) : hi_r[k];
        end
      end
    end
  endgenerate

  // quotient above one (first bit set with remainder) clamps
  assign quo = (hi_r[N] || q_r[N] > ljap_pkg::Q30One) ? ljap_pkg::Q30One : q_r[N];
endmodule

// ----- rtl/ljap_pow.sv -----
// sixth and twelfth power of a Q0.30 ratio, one multiply per stage
// four register stages; uses ljap_pkg
module ljap_pow (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ljap_pkg::QW-1:0]  x,
  output logic [ljap_pkg::QW-1:0]  p6,
  output logic [ljap_pkg::QW-1:0]  p12
);
  logic [ljap_pkg::QW-1:0] x2_r, x2b_r, x4_r, x6_r, x6b_r, x12_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r  <= ljap_pkg::mulq(x, x);
      x4_r  <= ljap_pkg::mulq(x2_r, x2_r);
      x2b_r <= x2_r;
      x6_r  <= ljap_pkg::mulq(x4_r, x2b_r);
      x12_r <= ljap_pkg::mulq(x6_r, x6_r);
      x6b_r <= x6_r;
    end
  end

  assign p6  = x6b_r;
  assign p12 = x12_r;
endmodule

// ----- test/tb_lj_attractive_pair_potential.sv -----
// testbench for lj_attractive_pair_potential: directed table, then random streams of
// parameter loads and pair evaluations under both cutoff modes, checked against a predictor
// depends on ljap_pkg, ljap_stream_if and the rtl top level
`timescale 1ns / 100ps

module tb_lj_attractive_pair_potential;

  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 60;
  localparam logic [1:0] AddrCutShift = 2'd0;

  typedef struct packed {
    logic signed [31:0] energy;
    logic [1:0]         region;
    logic               saturated;
  } pair_result_t;

  typedef struct {
    logic        cmd;
    logic [1:0]  si;
    logic [1:0]  sj;
    logic [23:0] sep;
    logic [23:0] sig;
    logic [23:0] eps;
    logic [23:0] cut;
    bit          typed;   // expected result given in the row
    pair_result_t res;
  } pair_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  ljap_in_if  in_ch ();
  ljap_out_if out_ch ();

  lj_attractive_pair_potential dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state: pair tables, which entries are loaded, cutoff mode
  logic [23:0] pair_sigma [ljap_pkg::DepthT];
  logic [23:0] pair_eps [ljap_pkg::DepthT];
  logic [23:0] pair_cut [ljap_pkg::DepthT];
  bit          pair_loaded [ljap_pkg::DepthT];
  bit          shifted_mode;

  pair_result_t energy_queue [$];
  int errors = 0;
  int cycles = 0;
  bit quiet_run = 0;   // no idling on either side

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Q0.30 ratio num/den, limited to one
  function automatic longint unsigned ratio_q30(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    if (den == 0) return 0;
    q = (num << 30) / den;
    return (q > 64'd1073741824) ? 64'd1073741824 : q;
  endfunction

  function automatic void sixth_twelfth(input longint unsigned x, output longint unsigned p6,
                                        output longint unsigned p12);
    longint unsigned x2, x4;
    x2  = (x * x) >> 30;
    x4  = (x2 * x2) >> 30;
    p6  = (x4 * x2) >> 30;
    p12 = (p6 * p6) >> 30;
  endfunction

  function automatic pair_result_t pair_energy(input logic [3:0] idx, input logic [23:0] r);
    pair_result_t res;
    longint unsigned sg, ep, ct, x6, x12, c6, c12, mag, rounded;
    longint d;
    res = '0;
    sg = pair_sigma[idx];
    ep = pair_eps[idx];
    ct = pair_cut[idx];
    if (r < sg) begin
      res.region = ljap_pkg::RegionCore;
    end else if (shifted_mode && r > ct) begin
      res.region = ljap_pkg::RegionBeyond;
    end else begin
      sixth_twelfth(ratio_q30(sg, r), x6, x12);
      // clamp to the well minimum once (s/r)^6 passes one half
      if (x6 > 64'd536870912) begin
        x6 = 64'd536870912;
        x12 = 64'd268435456;
        res.region = ljap_pkg::RegionWell;
      end else begin
        res.region = ljap_pkg::RegionTail;
      end
      d = longint'(x12) - longint'(x6);
      if (shifted_mode) begin
        sixth_twelfth(ratio_q30(sg, ct), c6, c12);
        d = d - (longint'(c12) - longint'(c6));
      end
      mag = (d < 0) ? longint'(-d) : d;
      rounded = (4 * ep * mag + 64'd536870912) >> 30;
      if (d >= 0 && rounded > 64'h7FFF_FFFF) begin
        res.energy = 32'h7FFF_FFFF;
        res.saturated = 1'b1;
      end else if (d < 0 && rounded > 64'h8000_0000) begin
        res.energy = 32'h8000_0000;
        res.saturated = 1'b1;
      end else begin
        res.energy = (d < 0) ? -rounded[31:0] : rounded[31:0];
      end
    end
    return res;
  endfunction

  // drive one item, wait for its transfer, then update the prediction
  task automatic send_pair(input pair_row_t row);
    logic [3:0] idx;
    idx = {row.si, row.sj};
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= row.cmd;
    in_ch.species_i     <= row.si;
    in_ch.species_j     <= row.sj;
    in_ch.distance      <= row.sep;
    in_ch.sigma_value   <= row.sig;
    in_ch.epsilon_value <= row.eps;
    in_ch.cutoff_value  <= row.cut;
    do @(posedge clk); while (!in_ch.ready);
    if (row.cmd == ljap_pkg::CmdLoad) begin
      pair_sigma[idx]  = row.sig;
      pair_eps[idx]    = row.eps;
      pair_cut[idx]    = row.cut;
      pair_loaded[idx] = 1;
    end else if (row.typed) begin
      energy_queue.push_back(row.res);
    end else begin
      energy_queue.push_back(pair_energy(idx, row.sep));
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (energy_queue.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // register write: setup cycle, then access cycle
  task automatic write_cut_shift(input bit value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= AddrCutShift;
    cfg_pwdata  <= {31'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    shifted_mode = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [23:0] clip24(input longint unsigned v);
    return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction

  // random item: mostly physical loads and distances from near sigma to past the cutoff
  function automatic pair_row_t random_pair();
    pair_row_t row;
    longint unsigned sg, ct;
    logic [3:0] idx;
    row.typed = 0;
    row.res   = '0;
    row.si    = 2'($urandom_range(0, 3));
    row.sj    = 2'($urandom_range(0, 3));
    row.sep   = 24'($urandom);
    row.sig   = 24'($urandom);
    row.eps   = 24'($urandom);
    row.cut   = 24'($urandom);
    idx = {row.si, row.sj};
    row.cmd = ($urandom_range(0, 4) == 0 || !pair_loaded[idx]) ? ljap_pkg::CmdLoad
                                                               : ljap_pkg::CmdEval;
    if (row.cmd == ljap_pkg::CmdLoad && $urandom_range(0, 4) != 0) begin
      row.sig = 24'($urandom_range(24'h00_8000, 24'h10_0000));
      row.cut = clip24(row.sig + $urandom_range(0, 4 * row.sig));
    end else if (row.cmd == ljap_pkg::CmdEval && $urandom_range(0, 4) != 0) begin
      sg = pair_sigma[idx];
      ct = pair_cut[idx];
      row.sep = clip24($urandom_range(32'(sg * 3 / 4),
                                      32'((ct > sg ? ct : sg) * 5 / 4 + 1)));
    end
    return row;
  endfunction

  // result side: random stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet_run || !rst_n) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    pair_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (energy_queue.size() == 0) begin
        report("unexpected result, energy", out_ch.energy, 0);
      end else begin
        want = energy_queue.pop_front();
        if (out_ch.energy !== want.energy) report("energy", out_ch.energy, want.energy);
        if (out_ch.region !== want.region) report("region", out_ch.region, want.region);
        if (out_ch.saturated !== want.saturated)
          report("saturated", out_ch.saturated, want.saturated);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // directed rows, all under the reset mode (cut and shift)
  pair_row_t directed [$];
  function automatic void add_row(input logic cmd, input logic [1:0] si, input logic [1:0] sj,
                                  input logic [23:0] sep, input logic [23:0] sig,
                                  input logic [23:0] eps, input logic [23:0] cut,
                                  input bit typed, input logic [1:0] region);
    pair_row_t row;
    row = '{cmd, si, sj, sep, sig, eps, cut, typed, '{32'sd0, region, 1'b0}};
    directed.push_back(row);
  endfunction

  initial begin
    pair_row_t row;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = ljap_pkg::CmdEval;
    in_ch.species_i = '0;
    in_ch.species_j = '0;
    in_ch.distance = '0;
    in_ch.sigma_value = '0;
    in_ch.epsilon_value = '0;
    in_ch.cutoff_value = '0;
    out_ch.ready = 1'b1;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    shifted_mode = 1;
    foreach (pair_loaded[k]) pair_loaded[k] = 0;

    // loads: unit pair, zero sigma and cutoff, all-ones, unit sigma with full depth
    add_row(ljap_pkg::CmdLoad, 0, 0, 0, 24'h04_0000, 24'h01_0000, 24'h0A_0000, 0,
            ljap_pkg::RegionCore);
    add_row(ljap_pkg::CmdLoad, 1, 2, 0, 24'h00_0000, 24'hFF_FFFF, 24'h00_0000, 0,
            ljap_pkg::RegionCore);
    add_row(ljap_pkg::CmdLoad, 3, 3, 0, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 0,
            ljap_pkg::RegionCore);
    add_row(ljap_pkg::CmdLoad, 2, 1, 0, 24'h04_0000, 24'hFF_FFFF, 24'hFF_FFFF, 0,
            ljap_pkg::RegionCore);
    // inside the core
    add_row(ljap_pkg::CmdEval, 0, 0, 24'h00_0000, 0, 0, 0, 1, ljap_pkg::RegionCore);
    add_row(ljap_pkg::CmdEval, 0, 0, 24'h03_FFFF, 0, 0, 0, 1, ljap_pkg::RegionCore);
    add_row(ljap_pkg::CmdEval, 3, 3, 24'hFF_FFFE, 0, 0, 0, 1, ljap_pkg::RegionCore);
    // clamped well, tail, exactly at the cutoff
    add_row(ljap_pkg::CmdEval, 0, 0, 24'h04_0000, 0, 0, 0, 0, ljap_pkg::RegionCore);
    add_row(ljap_pkg::CmdEval, 0, 0, 24'h04_8000, 0, 0, 0, 0, ljap_pkg::RegionCore);
    add_row(ljap_pkg::CmdEval, 0, 0, 24'h06_0000, 0, 0, 0, 0, ljap_pkg::RegionCore);
    add_row(ljap_pkg::CmdEval, 0, 0, 24'h0A_0000, 0, 0, 0, 0, ljap_pkg::RegionCore);
    add_row(ljap_pkg::CmdEval, 3, 3, 24'hFF_FFFF, 0, 0, 0, 0, ljap_pkg::RegionCore);
    add_row(ljap_pkg::CmdEval, 2, 1, 24'h04_0000, 0, 0, 0, 0, ljap_pkg::RegionCore);
    add_row(ljap_pkg::CmdEval, 2, 1, 24'h0F_FFFF, 0, 0, 0, 0, ljap_pkg::RegionCore);
    add_row(ljap_pkg::CmdEval, 2, 1, 24'hFF_FFFF, 0, 0, 0, 0, ljap_pkg::RegionCore);
    // zero sigma at zero distance: zero divisor
    add_row(ljap_pkg::CmdEval, 1, 2, 24'h00_0000, 0, 0, 0, 0, ljap_pkg::RegionCore);
    // beyond the cutoff
    add_row(ljap_pkg::CmdEval, 0, 0, 24'h0A_0001, 0, 0, 0, 1, ljap_pkg::RegionBeyond);
    add_row(ljap_pkg::CmdEval, 0, 0, 24'hFF_FFFF, 0, 0, 0, 1, ljap_pkg::RegionBeyond);
    add_row(ljap_pkg::CmdEval, 1, 2, 24'hFF_FFFF, 0, 0, 0, 1, ljap_pkg::RegionBeyond);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) send_pair(directed[k]);
    wait_idle();

    // random phases across both modes, last one without idling
    for (int phase = 0; phase < 4; phase++) begin
      write_cut_shift(phase[0] == 0 ? 1'b0 : 1'b1);
      if (phase == 3) quiet_run = 1;
      for (int n = 0; n < 135; n++) begin
        row = random_pair();
        send_pair(row);
      end
      wait_idle();
    end

    if (errors == 0 && energy_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ljap_pkg.sv
rtl/ljap_stream_if.sv
rtl/ljap_div.sv
rtl/ljap_pow.sv
rtl/lj_attractive_pair_potential.sv
test/tb_lj_attractive_pair_potential.sv
